// ===== design/quadratic_probe_hash_table_unit_macros.svh =====
// assertion macros for the quadratic probe hash table unit
// no dependencies; included by the top level
`ifndef QUADRATIC_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define QPHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define QPHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define QPHT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QPHT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/qpht_pkg.sv =====
// shared constants, command codes and controller/datapath structs
// no dependencies
package qpht_pkg;
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_BITS   = 10;
	localparam int SIZE_BITS   = 11;
	localparam int PADDR_BITS  = 3;
	localparam int PDATA_BITS  = 32;
	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 11'd1021;

	localparam logic [1:0] CMD_FIND     = 2'd0;
	localparam logic [1:0] CMD_INSERT   = 2'd1;
	localparam logic [1:0] CMD_RETRIEVE = 2'd2;
	localparam logic [1:0] CMD_NOP      = 2'd3;

	localparam logic REG_SLOT_COUNT = 1'b0;

	typedef struct packed {
		logic clr_wr;
		logic load_in;
		logic div_step;
		logic rd_home;
		logic rd_next;
		logic rd_retr;
		logic ins_wr;
		logic res_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       div_last;
		logic [1:0] cmd;
		logic       occ;
		logic       match;
		logic       at_limit;
		logic       out_free;
	} ctrl_stat_t;
endpackage

// ===== design/qpht_if.sv =====
// request and response channel interfaces
// depends on qpht_pkg
interface qpht_req_if #(parameter int KEY_BITS = 32);
	logic                           valid;
	logic                           ready;
	logic [1:0]                     command;
	logic [KEY_BITS-1:0]            key;
	logic [qpht_pkg::ADDR_BITS-1:0] position;
	modport source (output valid, command, key, position, input ready);
	modport sink (input valid, command, key, position, output ready);
endinterface

interface qpht_rsp_if #(parameter int KEY_BITS = 32);
	logic                           valid;
	logic                           ready;
	logic [qpht_pkg::ADDR_BITS-1:0] slot;
	logic [KEY_BITS-1:0]            stored_key;
	logic                           found;
	logic                           inserted;
	logic                           table_full;
	modport source (output valid, slot, stored_key, found, inserted, table_full, input ready);
	modport sink (input valid, slot, stored_key, found, inserted, table_full, output ready);
endinterface

// ===== design/quadratic_probe_hash_table_unit.sv =====
// top level of the quadratic probe hash table unit: apb register, controller and datapath
// depends on qpht_pkg, qpht_if, qpht_ctrl, qpht_dp and the assertion macro header
//
// usage: commands arrive as beats on req (find, insert, retrieve, no operation);
// each accepted beat yields exactly one response beat on rsp.
// the table holds up to 1024 keys; the slot count register (apb address 0) sets the
// slots in use.
// one command is worked on at a time; req.ready is high only while the unit is idle.
// find/insert: a dispatch step, the division for the home slot (four remainder
// digits a cycle), the home read, then the probes, one a cycle, through the cell
// ram read port; the probes taken, the home read among them, are at most the slot
// count/2 + 1.
// retrieve and no operation: a dispatch step, then the response; retrieve reads
// the cell at the given position.
// after reset a clearing pass empties every cell; req.ready stays low meanwhile,
// while apb writes are taken as ever.
// the response sits in an output register; a stalled rsp does not stop the next
// command being accepted and worked, only its hand-off waits for rsp.ready.
`include "quadratic_probe_hash_table_unit_macros.svh"
module quadratic_probe_hash_table_unit #(
	parameter int KEY_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	qpht_req_if.sink                        req,
	qpht_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [qpht_pkg::PADDR_BITS-1:0] paddr,
	input  logic [qpht_pkg::PDATA_BITS-1:0] pwdata,
	output logic [qpht_pkg::PDATA_BITS-1:0] prdata,
	output logic                            pready
);
	logic [qpht_pkg::SIZE_BITS-1:0] size_q;
	logic                           in_ready;
	logic                           accept;
	qpht_pkg::ctrl_cmd_t            cmd;
	qpht_pkg::ctrl_stat_t           stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= qpht_pkg::SIZE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == qpht_pkg::REG_SLOT_COUNT) begin
			size_q <= pwdata[qpht_pkg::SIZE_BITS-1:0];
		end
	end

	assign prdata = (paddr[2] == qpht_pkg::REG_SLOT_COUNT) ?
		qpht_pkg::PDATA_BITS'(size_q) : '0;

	assign req.ready = in_ready;
	assign accept    = req.valid & in_ready;

	qpht_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	qpht_dp #(
		.KEY_BITS(KEY_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_command    (req.command),
		.in_key        (req.key),
		.in_position   (req.position),
		.slot_count    (size_q),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_slot      (rsp.slot),
		.out_stored_key(rsp.stored_key),
		.out_found     (rsp.found),
		.out_inserted  (rsp.inserted),
		.out_table_full(rsp.table_full)
	);

	`QPHT_ASSERT_NXT(a_one_at_a_time, clk, arst_n, accept, !req.ready)
	`QPHT_ASSERT_IMP(a_ins_excl, clk, arst_n, rsp.valid && rsp.inserted, !rsp.found && !rsp.table_full)
	`QPHT_ASSERT_IMP(a_full_excl, clk, arst_n, rsp.valid && rsp.table_full, !rsp.found)
	`QPHT_ASSERT_IMP(a_write_done, clk, arst_n, cmd.ins_wr, cmd.res_load && !cmd.clr_wr)
endmodule

// ===== design/qpht_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module qpht_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== design/qpht_dp.sv =====
// datapath: divider for the home slot, probe address walk, cell ram and result register
// depends on qpht_pkg and qpht_ram
module qpht_dp #(
	parameter int KEY_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  qpht_pkg::ctrl_cmd_t            cmd,
	output qpht_pkg::ctrl_stat_t           stat,
	input  logic [1:0]                     in_command,
	input  logic [KEY_BITS-1:0]            in_key,
	input  logic [qpht_pkg::ADDR_BITS-1:0] in_position,
	input  logic [qpht_pkg::SIZE_BITS-1:0] slot_count,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [qpht_pkg::ADDR_BITS-1:0] out_slot,
	output logic [KEY_BITS-1:0]            out_stored_key,
	output logic                           out_found,
	output logic                           out_inserted,
	output logic                           out_table_full
);
	localparam int SB        = qpht_pkg::SIZE_BITS;
	localparam int AB        = qpht_pkg::ADDR_BITS;
	localparam int KEY_PAD   = ((KEY_BITS + 3) / 4) * 4;
	localparam int DIV_STEPS = KEY_PAD / 4;
	localparam int DCW       = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	logic [1:0]          cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [AB-1:0]       posin_q;
	logic [SB-1:0]       n_q;
	logic [SB-1:0]       rem_q;
	logic [KEY_PAD-1:0]  kshift_q;
	logic [DCW-1:0]      dcnt_q;
	logic [SB-1:0]       pos_q;
	logic [SB-1:0]       cnt_q;
	logic [SB-1:0]       odd_q;
	logic [AB-1:0]       clr_q;
	logic                ovalid_q;

	logic [SB-1:0]       n_eff;
	logic [SB-1:0]       rem_nxt;
	logic [SB:0]         sum;
	logic [SB-1:0]       pos_nxt;
	logic                ram_we;
	logic [AB-1:0]       ram_waddr;
	logic [KEY_BITS:0]   ram_wdata;
	logic                ram_re;
	logic [AB-1:0]       ram_raddr;
	logic [KEY_BITS:0]   ram_rdata;
	logic                occ;
	logic                match;

	always_comb begin
		n_eff = slot_count;
		if (slot_count == '0) begin
			n_eff = SB'(1);
		end else if (slot_count > SB'(qpht_pkg::TABLE_DEPTH)) begin
			n_eff = SB'(qpht_pkg::TABLE_DEPTH);
		end
	end

	// four remainder digits a cycle
	always_comb begin
		logic [SB-1:0] r;
		r = rem_q;
		for (int i = 0; i < 4; i++) begin
			r = {r[SB-2:0], kshift_q[KEY_PAD-1-i]};
			if (r >= n_q) begin
				r = r - n_q;
			end
		end
		rem_nxt = r;
	end

	always_comb begin
		sum = {1'b0, pos_q} + {1'b0, odd_q};
		if (sum >= {1'b0, n_q}) begin
			sum = sum - {1'b0, n_q};
		end
		pos_nxt = sum[SB-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q    <= in_command;
			key_q    <= in_key;
			posin_q  <= in_position;
			n_q      <= n_eff;
			rem_q    <= '0;
			kshift_q <= KEY_PAD'(in_key);
			dcnt_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q    <= rem_nxt;
			kshift_q <= kshift_q << 4;
			dcnt_q   <= dcnt_q + DCW'(1);
		end
		if (cmd.rd_home) begin
			pos_q <= rem_q;
			cnt_q <= '0;
			odd_q <= SB'(1);
		end else if (cmd.rd_next) begin
			pos_q <= pos_nxt;
			cnt_q <= cnt_q + SB'(1);
			odd_q <= odd_q + SB'(2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + AB'(1);
		end
	end

	always_comb begin
		ram_we    = cmd.clr_wr | cmd.ins_wr;
		ram_waddr = cmd.clr_wr ? clr_q : AB'(pos_q);
		ram_wdata = cmd.clr_wr ? '0 : {1'b1, key_q};
		ram_re    = cmd.rd_home | cmd.rd_next | cmd.rd_retr;
		ram_raddr = posin_q;
		if (cmd.rd_home) begin
			ram_raddr = AB'(rem_q);
		end else if (cmd.rd_next) begin
			ram_raddr = AB'(pos_nxt);
		end
	end

	qpht_ram #(
		.WIDTH(KEY_BITS + 1),
		.DEPTH(qpht_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign occ   = ram_rdata[KEY_BITS];
	assign match = (ram_rdata[KEY_BITS-1:0] == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.res_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd_q)
				qpht_pkg::CMD_FIND, qpht_pkg::CMD_INSERT: begin
					out_slot       <= AB'(pos_q);
					out_found      <= occ & match;
					out_inserted   <= (cmd_q == qpht_pkg::CMD_INSERT) & ~occ;
					out_table_full <= occ & ~match;
					if (!occ && cmd_q == qpht_pkg::CMD_INSERT) begin
						out_stored_key <= key_q;
					end else begin
						out_stored_key <= occ ? ram_rdata[KEY_BITS-1:0] : '0;
					end
				end
				qpht_pkg::CMD_RETRIEVE: begin
					out_slot       <= posin_q;
					out_found      <= occ;
					out_inserted   <= 1'b0;
					out_table_full <= 1'b0;
					out_stored_key <= ram_rdata[KEY_BITS-1:0];
				end
				default: begin
					out_slot       <= '0;
					out_found      <= 1'b0;
					out_inserted   <= 1'b0;
					out_table_full <= 1'b0;
					out_stored_key <= '0;
				end
			endcase
		end
	end

	assign out_valid = ovalid_q;

	always_comb begin
		stat          = '0;
		stat.clr_last = &clr_q;
		stat.div_last = (dcnt_q == DCW'(DIV_STEPS - 1));
		stat.cmd      = cmd_q;
		stat.occ      = occ;
		stat.match    = match;
		stat.at_limit = (cnt_q >= (n_q >> 1));
		stat.out_free = ~ovalid_q | out_ready;
	end
endmodule

// ===== design/qpht_ctrl.sv =====
// controller state machine: clearing pass, division, probe walk and result hand-off
// depends on qpht_pkg
module qpht_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	output logic                  in_ready,
	input  qpht_pkg::ctrl_stat_t  stat,
	output qpht_pkg::ctrl_cmd_t   cmd
);
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DISP  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_HOME  = 3'd4;
	localparam logic [2:0] ST_CHECK = 3'd5;
	localparam logic [2:0] ST_RWAIT = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       done;

	assign done = ~stat.occ | stat.match | stat.at_limit;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = accept;
				if (accept) begin
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				case (stat.cmd)
					qpht_pkg::CMD_FIND, qpht_pkg::CMD_INSERT: state_d = ST_DIV;
					qpht_pkg::CMD_RETRIEVE: begin
						cmd.rd_retr = 1'b1;
						state_d     = ST_RWAIT;
					end
					default: state_d = ST_FIN;
				endcase
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_HOME;
				end
			end
			ST_HOME: begin
				cmd.rd_home = 1'b1;
				state_d     = ST_CHECK;
			end
			ST_CHECK: begin
				if (!done) begin
					cmd.rd_next = 1'b1;
				end else if (stat.out_free) begin
					cmd.res_load = 1'b1;
					cmd.ins_wr   = (stat.cmd == qpht_pkg::CMD_INSERT) & ~stat.occ;
					state_d      = ST_IDLE;
				end
			end
			ST_RWAIT, ST_FIN: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
